[hdl/first_fit_heap_allocator_defines.svh]
// assertion helpers used by the top level, which checks itself
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// consequent must hold in the cycle in which the antecedent holds
`define FFHA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// condition must hold at every clock edge out of reset
`define FFHA_ASSERT_ALWAYS(label, cond) `FFHA_ASSERT_IMPLY(label, 1'b1, cond)

`endif

[hdl/ffha_pkg.sv]
package ffha_pkg;

    localparam int MAX_BLOCKS     = 64;
    localparam int HEADER_BYTES   = 20;
    localparam int MIN_SPLIT_REST = 4;
    localparam int IDX_W          = $clog2(MAX_BLOCKS);
    localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W         = 24;
    localparam int ADDR_W         = 32;
    localparam int HSIZE_W        = 25;
    localparam int CFG_IDX_W      = 1;

    localparam logic [HSIZE_W-1:0] HEAP_SIZE_RESET = 25'd1048576;
    localparam logic [SIZE_W-1:0]  HDR_SZ          = SIZE_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0]  HDR_AD          = ADDR_W'(HEADER_BYTES);
    localparam logic [SIZE_W:0]    SPLIT_EXTRA     = (SIZE_W + 1)'(HEADER_BYTES + MIN_SPLIT_REST);
    localparam logic [CNT_W-1:0]   MAX_CNT         = CNT_W'(MAX_BLOCKS);

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADARG  = 2'd2,
        ST_BADADDR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_BAD   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [SIZE_W-1:0] offset;
        logic [SIZE_W-1:0] payload;
        logic              is_free;
    } entry_t;

    typedef struct packed {
        kind_t             kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } res_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic               load;
        logic [HSIZE_W-1:0] load_size;
    } cfg_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } stat_t;

    // first block payload for a given heap size, clamped at both ends
    function automatic logic [SIZE_W-1:0] init_payload(input logic [HSIZE_W-1:0] hs);
        logic [HSIZE_W-1:0] p;
        begin
            if (hs < HSIZE_W'(HEADER_BYTES))
                p = '0;
            else
                p = hs - HSIZE_W'(HEADER_BYTES);
            if (p[HSIZE_W-1])
                return '1;
            return p[SIZE_W-1:0];
        end
    endfunction

endpackage

[hdl/ffha_ram.sv]
module ffha_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ffha_front.sv]
module ffha_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        func,
    input  logic [ffha_pkg::SIZE_W-1:0] req_size,
    input  logic [ffha_pkg::ADDR_W-1:0] free_addr,
    output logic                        req_valid,
    output ffha_pkg::req_t              req,
    input  logic                        req_pop
);

    ffha_pkg::req_t q_reg [2];
    ffha_pkg::req_t q_next [2];
    logic [1:0]     cnt_reg, cnt_next;
    ffha_pkg::req_t in_req;
    logic           do_push, do_pop;
    logic [1:0]     wpos;

    // classify: bad arguments are settled here, the back end only answers them
    always_comb
    begin
        in_req.size = req_size;
        in_req.addr = free_addr;
        if (func)
            in_req.kind = (free_addr == '0) ? ffha_pkg::K_BAD : ffha_pkg::K_FREE;
        else
            in_req.kind = (req_size == '0) ? ffha_pkg::K_BAD : ffha_pkg::K_ALLOC;
    end

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[0];
    assign do_push   = push && !full;
    assign do_pop    = req_pop && req_valid;
    assign wpos      = cnt_reg - {1'b0, do_pop};

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        if (do_pop)
        begin
            q_next[0] = q_reg[1];
        end
        if (do_push)
        begin
            q_next[wpos[0]] = in_req;
        end
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule

[hdl/ffha_back.sv]
module ffha_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ffha_pkg::cfg_t cfg,
    input  logic           req_valid,
    input  ffha_pkg::req_t req,
    output logic           req_pop,
    output logic           res_valid,
    output ffha_pkg::res_t res,
    input  logic           res_pop,
    output ffha_pkg::stat_t stat
);

    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam int AW = ffha_pkg::ADDR_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_ALLOC_DEC, S_FREE_NCK, S_FREE_MRG,
        S_MOVE, S_FIN_A, S_FIN_B, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     count_new_reg, count_new_next;
    logic              op_alloc_reg, op_alloc_next;
    logic [SW-1:0]     size_reg, size_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic [IW-1:0]     idx_reg, idx_next;
    ffha_pkg::entry_t  cur_reg, cur_next;
    ffha_pkg::entry_t  prev_reg, prev_next;
    logic              pv_reg, pv_next;
    logic              nx_reg, nx_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic              mv_up_reg, mv_up_next;
    logic [1:0]        mv_dist_reg, mv_dist_next;
    logic [CW-1:0]     mv_src_reg, mv_src_next;
    logic [CW-1:0]     mv_cnt_reg, mv_cnt_next;
    logic              mv_pend_reg, mv_pend_next;
    logic [IW-1:0]     mv_widx_reg, mv_widx_next;
    ffha_pkg::entry_t  fin_a_reg, fin_a_next;
    logic [IW-1:0]     fin_a_idx_reg, fin_a_idx_next;
    ffha_pkg::entry_t  fin_b_reg, fin_b_next;
    logic [IW-1:0]     fin_b_idx_reg, fin_b_idx_next;
    logic              two_wr_reg, two_wr_next;
    logic [AW-1:0]     res_addr_reg, res_addr_next;
    ffha_pkg::status_t res_status_reg, res_status_next;
    ffha_pkg::res_t    oq_reg [2];
    ffha_pkg::res_t    oq_next [2];
    logic [1:0]        oq_cnt_reg, oq_cnt_next;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    ffha_pkg::entry_t  ram_wdata, rdata;

    logic              push_res, do_res_pop;
    logic [1:0]        oq_wpos;
    logic [CW-1:0]     count_m1, idx_ext, mv_target, mv_start, mv_dst;
    logic [AW-1:0]     paddr;
    logic              fit, hit, split;
    logic [1:0]        merge_cnt;
    ffha_pkg::res_t    new_res;

    ffha_ram #(
        .DATA_W ($bits(ffha_pkg::entry_t)),
        .DEPTH  (ffha_pkg::MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign count_m1 = count_reg - CW'(1);
    assign idx_ext  = {1'b0, idx_reg};
    assign paddr    = cfg.base + AW'(rdata.offset) + ffha_pkg::HDR_AD;
    assign fit      = rdata.is_free && (rdata.payload >= size_reg);
    assign hit      = op_alloc_reg ? fit : (paddr == addr_reg);
    assign split    = ({1'b0, cur_reg.payload} >= ({1'b0, size_reg} + ffha_pkg::SPLIT_EXTRA))
                      && (count_reg < ffha_pkg::MAX_CNT);
    assign merge_cnt = {1'b0, nx_reg} + {1'b0, pv_reg};
    assign mv_dst   = pv_reg ? idx_ext : idx_ext + CW'(1);
    assign mv_start = mv_dst + CW'(merge_cnt);
    assign mv_target = mv_up_reg ? mv_src_reg + CW'(1) : mv_src_reg - CW'(mv_dist_reg);

    assign new_res.addr   = res_addr_reg;
    assign new_res.status = res_status_reg;
    assign do_res_pop     = res_pop && res_valid;
    assign oq_wpos        = oq_cnt_reg - {1'b0, do_res_pop};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        count_new_next  = count_new_reg;
        op_alloc_next   = op_alloc_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        rd_idx_next     = rd_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        pv_next         = pv_reg;
        nx_next         = nx_reg;
        sum_next        = sum_reg;
        mv_up_next      = mv_up_reg;
        mv_dist_next    = mv_dist_reg;
        mv_src_next     = mv_src_reg;
        mv_cnt_next     = mv_cnt_reg;
        mv_pend_next    = mv_pend_reg;
        mv_widx_next    = mv_widx_reg;
        fin_a_next      = fin_a_reg;
        fin_a_idx_next  = fin_a_idx_reg;
        fin_b_next      = fin_b_reg;
        fin_b_idx_next  = fin_b_idx_reg;
        two_wr_next     = two_wr_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = rd_idx_reg[IW-1:0];
        req_pop         = 1'b0;
        push_res        = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we            = 1'b1;
                ram_wdata.payload = ffha_pkg::init_payload(ffha_pkg::HEAP_SIZE_RESET);
                ram_wdata.is_free = 1'b1;
                count_next        = CW'(1);
                state_next        = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_pop      = 1'b1;
                    size_next    = req.size;
                    addr_next    = req.addr;
                    rd_idx_next  = '0;
                    chk_vld_next = 1'b0;
                    case (req.kind)
                        ffha_pkg::K_ALLOC:
                        begin
                            op_alloc_next = 1'b1;
                            state_next    = S_SCAN;
                        end
                        ffha_pkg::K_FREE:
                        begin
                            op_alloc_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            res_addr_next   = '0;
                            res_status_next = ffha_pkg::ST_BADARG;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // read one entry ahead of the one being checked
                if (rd_idx_reg < count_reg)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg[IW-1:0];
                    rd_idx_next  = rd_idx_reg + CW'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    if (hit)
                    begin
                        idx_next        = chk_idx_reg;
                        cur_next        = rdata;
                        res_addr_next   = op_alloc_reg ? paddr : '0;
                        res_status_next = ffha_pkg::ST_OK;
                        state_next      = op_alloc_reg ? S_ALLOC_DEC : S_FREE_NCK;
                    end
                    else if ({1'b0, chk_idx_reg} == count_m1)
                    begin
                        res_addr_next   = '0;
                        res_status_next = op_alloc_reg ? ffha_pkg::ST_NOFIT
                                                       : ffha_pkg::ST_BADADDR;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        prev_next = rdata;
                    end
                end
            end
            S_ALLOC_DEC:
            begin
                mv_pend_next = 1'b0;
                mv_up_next   = 1'b1;
                mv_dist_next = 2'd1;
                if (split)
                begin
                    mv_src_next       = count_m1;
                    mv_cnt_next       = count_m1 - idx_ext;
                    fin_a_next.offset = cur_reg.offset + ffha_pkg::HDR_SZ + size_reg;
                    fin_a_next.payload = cur_reg.payload - size_reg - ffha_pkg::HDR_SZ;
                    fin_a_next.is_free = 1'b1;
                    fin_a_idx_next    = idx_reg + IW'(1);
                    fin_b_next.offset = cur_reg.offset;
                    fin_b_next.payload = size_reg;
                    fin_b_next.is_free = 1'b0;
                    fin_b_idx_next    = idx_reg;
                    two_wr_next       = 1'b1;
                    count_new_next    = count_reg + CW'(1);
                end
                else
                begin
                    mv_cnt_next        = '0;
                    fin_a_next         = cur_reg;
                    fin_a_next.is_free = 1'b0;
                    fin_a_idx_next     = idx_reg;
                    two_wr_next        = 1'b0;
                    count_new_next     = count_reg;
                end
                state_next = S_MOVE;
            end
            S_FREE_NCK:
            begin
                // rdata holds the next entry, read during the last scan cycle
                nx_next  = ((idx_ext + CW'(1)) < count_reg) && rdata.is_free;
                pv_next  = (idx_reg != '0) && prev_reg.is_free;
                sum_next = cur_reg.payload;
                if (((idx_ext + CW'(1)) < count_reg) && rdata.is_free)
                begin
                    sum_next = cur_reg.payload + rdata.payload + ffha_pkg::HDR_SZ;
                end
                state_next = S_FREE_MRG;
            end
            S_FREE_MRG:
            begin
                if (pv_reg)
                begin
                    fin_a_next.offset  = prev_reg.offset;
                    fin_a_next.payload = prev_reg.payload + sum_reg + ffha_pkg::HDR_SZ;
                    fin_a_idx_next     = idx_reg - IW'(1);
                end
                else
                begin
                    fin_a_next.offset  = cur_reg.offset;
                    fin_a_next.payload = sum_reg;
                    fin_a_idx_next     = idx_reg;
                end
                fin_a_next.is_free = 1'b1;
                two_wr_next    = 1'b0;
                mv_up_next     = 1'b0;
                mv_dist_next   = merge_cnt;
                mv_src_next    = mv_start;
                mv_cnt_next    = (merge_cnt != 2'd0) ? count_reg - mv_start : '0;
                mv_pend_next   = 1'b0;
                count_new_next = count_reg - CW'(merge_cnt);
                state_next     = S_MOVE;
            end
            S_MOVE:
            begin
                if (mv_cnt_reg != '0)
                begin
                    ram_raddr    = mv_src_reg[IW-1:0];
                    mv_pend_next = 1'b1;
                    mv_widx_next = mv_target[IW-1:0];
                    mv_src_next  = mv_up_reg ? mv_src_reg - CW'(1) : mv_src_reg + CW'(1);
                    mv_cnt_next  = mv_cnt_reg - CW'(1);
                end
                else
                begin
                    mv_pend_next = 1'b0;
                end
                if (mv_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = mv_widx_reg;
                    ram_wdata = rdata;
                end
                if ((mv_cnt_reg == '0) && !mv_pend_reg)
                begin
                    state_next = S_FIN_A;
                end
            end
            S_FIN_A:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fin_a_idx_reg;
                ram_wdata  = fin_a_reg;
                count_next = count_new_reg;
                state_next = two_wr_reg ? S_FIN_B : S_DONE;
            end
            S_FIN_B:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fin_b_idx_reg;
                ram_wdata  = fin_b_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (oq_cnt_reg != 2'd2)
                begin
                    push_res   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // heap size write rebuilds the table as one free block
        if (cfg.load)
        begin
            ram_we            = 1'b1;
            ram_waddr         = '0;
            ram_wdata         = '0;
            ram_wdata.payload = ffha_pkg::init_payload(cfg.load_size);
            ram_wdata.is_free = 1'b1;
            count_next        = CW'(1);
        end
    end

    // result queue
    always_comb
    begin
        oq_next[0] = oq_reg[0];
        oq_next[1] = oq_reg[1];
        if (do_res_pop)
        begin
            oq_next[0] = oq_reg[1];
        end
        if (push_res)
        begin
            oq_next[oq_wpos[0]] = new_res;
        end
        oq_cnt_next = oq_cnt_reg + {1'b0, push_res} - {1'b0, do_res_pop};
    end

    assign res_valid  = (oq_cnt_reg != 2'd0);
    assign res        = oq_reg[0];
    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            count_reg   <= CW'(1);
            chk_vld_reg <= 1'b0;
            mv_pend_reg <= 1'b0;
            oq_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            mv_pend_reg <= mv_pend_next;
            oq_cnt_reg  <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_new_reg  <= count_new_next;
        op_alloc_reg   <= op_alloc_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        chk_idx_reg    <= chk_idx_next;
        idx_reg        <= idx_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        pv_reg         <= pv_next;
        nx_reg         <= nx_next;
        sum_reg        <= sum_next;
        mv_up_reg      <= mv_up_next;
        mv_dist_reg    <= mv_dist_next;
        mv_src_reg     <= mv_src_next;
        mv_cnt_reg     <= mv_cnt_next;
        mv_widx_reg    <= mv_widx_next;
        fin_a_reg      <= fin_a_next;
        fin_a_idx_reg  <= fin_a_idx_next;
        fin_b_reg      <= fin_b_next;
        fin_b_idx_reg  <= fin_b_idx_next;
        two_wr_reg     <= two_wr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        oq_reg[0]      <= oq_next[0];
        oq_reg[1]      <= oq_next[1];
    end

endmodule

[hdl/first_fit_heap_allocator.sv]
// channel   | handshake           | transaction carries
// ----------+---------------------+------------------------------------
// request   | push / full         | func, req_size, free_addr
// result    | pop / empty         | result_addr, status
// config    | cfg_en (no wait)    | cfg_index, cfg_data
//
// once a request leaves the request queue, the scan and the shift of the later
// entries go through the single read port, then come one or two table
// writes and the result push; bad arguments go straight to the result push
// after reset the first table entry is written in the init state; requests queue
// up meanwhile and no further clearing pass is needed
// two request slots and two result slots let either side stall on its own
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    // request queue side
    input  logic                           push,
    output logic                           full,
    input  logic                           func,
    input  logic [ffha_pkg::SIZE_W-1:0]    req_size,
    input  logic [ffha_pkg::ADDR_W-1:0]    free_addr,
    // result queue side
    output logic                           empty,
    input  logic                           pop,
    output logic [ffha_pkg::ADDR_W-1:0]    result_addr,
    output logic [1:0]                     status,
    // configuration writes
    input  logic                           cfg_en,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]    cfg_data
);

    logic [ffha_pkg::ADDR_W-1:0] base_reg, base_next;
    ffha_pkg::cfg_t  cfg;
    ffha_pkg::req_t  req;
    ffha_pkg::res_t  res;
    ffha_pkg::stat_t stat;
    logic            req_valid, req_pop, res_valid;
    logic            load;

    // register decode: base is held here, a size write reloads the table
    always_comb
    begin
        base_next = base_reg;
        load      = 1'b0;
        if (cfg_en)
        begin
            unique case (cfg_index)
                ffha_pkg::CFG_HEAP_BASE: base_next = cfg_data;
                ffha_pkg::CFG_HEAP_SIZE: load      = 1'b1;
                default:                 load      = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    assign cfg.base      = base_reg;
    assign cfg.load      = load;
    assign cfg.load_size = cfg_data[ffha_pkg::HSIZE_W-1:0];

    // front end: request queue and classification
    ffha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .req_size  (req_size),
        .free_addr (free_addr),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop)
    );

    // back end: table walk, split and merge, result queue
    ffha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop),
        .stat      (stat)
    );

    assign empty       = !res_valid;
    assign result_addr = res.addr;
    assign status      = res.status;

    // table always holds at least one block and never more than its depth
    `FFHA_ASSERT_ALWAYS(a_count_range, (stat.count != '0) && (stat.count <= ffha_pkg::MAX_CNT))
    // only a successful allocate hands out an address
    `FFHA_ASSERT_IMPLY(a_fail_no_addr, !empty && (status != 2'(ffha_pkg::ST_OK)), result_addr == '0)

endmodule
